// File: hw/rtl/mme_pkg.sv
// shared types and constants of the matrix multiply engine
// no dependencies; imported by mme_mac and matrix_multiply_engine_top
package mme_pkg;

	localparam int MAX_DIM_DEF   = 8;
	localparam int ELEM_BITS_DEF = 16;

	// fixed field widths of the stream words
	localparam int CFG_W        = 4;
	localparam int IDX_W        = 3;
	localparam int IN_VAL_W     = 16;
	localparam int VAL_W        = 36;
	localparam int IN_TDATA_W   = 24;
	localparam int OUT_TDATA_W  = 48;
	localparam int KIND_W       = 2;
	localparam int CFG_IDX_W    = 2;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_A_ROWS     = 2'd0,
		REG_INNER_SIZE = 2'd1,
		REG_B_COLS     = 2'd2
	} cfg_reg_t;

	typedef enum logic [KIND_W-1:0] {
		KIND_LOAD_A  = 2'd0,
		KIND_LOAD_B  = 2'd1,
		KIND_COMPUTE = 2'd2
	} kind_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_READ,
		ST_LOAD,
		ST_MUL,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic clr;
		logic load;
		logic step;
	} mac_ctl_t;

endpackage

// File: hw/rtl/mme_ram.sv
// generic single-write, single-read ram with registered read data
// no dependencies
module mme_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

// File: hw/rtl/mme_mac.sv
// bit-serial multiply-accumulate: one multiplier bit per cycle, lsb first
// depends on mme_pkg
module mme_mac
	import mme_pkg::*;
#(
	parameter int ELEM_BITS = ELEM_BITS_DEF,
	parameter int ACC_W     = 2 * ELEM_BITS_DEF + 4
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  mac_ctl_t                    ctl,
	input  logic signed [ELEM_BITS-1:0] a_elem,
	input  logic        [ELEM_BITS-1:0] b_elem,
	output logic signed [ACC_W-1:0]     acc,
	output logic                        done
);

	localparam int CNT_W = $clog2(ELEM_BITS);

	logic signed [ACC_W-1:0]     mcand_q;
	logic        [ELEM_BITS-1:0] mplier_q;
	logic        [CNT_W-1:0]     cnt_q;
	logic signed [ACC_W-1:0]     acc_q;
	logic signed [ACC_W-1:0]     addend;
	logic                        msb_bit;

	// the sign bit of the multiplier weighs negative
	assign msb_bit = (cnt_q == CNT_W'(ELEM_BITS - 1));
	assign addend  = mplier_q[0] ? mcand_q : '0;
	assign done    = ctl.step && msb_bit;
	assign acc     = acc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			acc_q <= '0;
		end else if (ctl.clr) begin
			acc_q <= '0;
		end else if (ctl.load) begin
			cnt_q <= '0;
		end else if (ctl.step) begin
			acc_q <= msb_bit ? (acc_q - addend) : (acc_q + addend);
			cnt_q <= cnt_q + CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			mcand_q  <= ACC_W'(a_elem);
			mplier_q <= b_elem;
		end else if (ctl.step) begin
			mcand_q  <= mcand_q <<< 1;
			mplier_q <= mplier_q >> 1;
		end
	end

endmodule

// File: hw/rtl/matrix_multiply_engine_top.sv
// matrix multiply engine top: command decode, element stores, sequencer, output register
// depends on mme_pkg, mme_ram, mme_mac
//
// input words on s_axis: tuser holds the kind; load A and load B words write one
// element into its store (one word per cycle while idle), loads outside the
// configured size are dropped. a compute word makes the engine emit every element
// of C = A x B on m_axis in row-major order, tlast on the final element.
// per inner term the sequencer passes a ram read state, an operand load state and
// the bit-serial multiplier, one multiplier bit per step; per element an emit
// state then hands the sum to the output register. s_axis_tready is low for the
// whole product and returns high in the cycle after the last element is moved
// into the output register.
// the output register lets the next element be computed while one waits; a
// stalled receiver holds the sequencer only when a second finished element has
// nowhere to go.
// reset clears the sequencer and output valid and sets all three size registers to
// MAX_DIM; store contents are undefined until written. the user must write size
// registers via cfg_we/cfg_index/cfg_wdata only while idle; not enforced by the block.
module matrix_multiply_engine_top
	import mme_pkg::*;
#(
	parameter int MAX_DIM   = MAX_DIM_DEF,
	parameter int ELEM_BITS = ELEM_BITS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_axis_tvalid,
	output logic                   s_axis_tready,
	input  logic [IN_TDATA_W-1:0]  s_axis_tdata,  // elem_row, elem_col, elem_value, zero pad
	input  logic [KIND_W-1:0]      s_axis_tuser,  // kind
	output logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	output logic [OUT_TDATA_W-1:0] m_axis_tdata,  // out_row, out_col, out_value, zero pad
	output logic                   m_axis_tlast,
	input  logic                   cfg_we,
	input  logic [CFG_IDX_W-1:0]   cfg_index,
	input  logic [CFG_W-1:0]       cfg_wdata
);

	localparam int DIM_W  = $clog2(MAX_DIM);
	localparam int ADDR_W = 2 * DIM_W;
	localparam int DEPTH  = 1 << ADDR_W;
	localparam int ACC_W  = 2 * ELEM_BITS + DIM_W + 1;
	localparam int SAT_W  = (ACC_W > VAL_W) ? ACC_W : VAL_W;

	state_t state_q, state_d;

	logic [CFG_W-1:0] a_rows_q, inner_size_q, b_cols_q, cfg_clamped;
	logic [DIM_W-1:0] i_q, j_q, k_q;
	logic             i_last, j_last, k_last;

	logic                       s_acc;
	kind_t                      kind;
	logic [IDX_W-1:0]           in_row, in_col;
	logic signed [IN_VAL_W-1:0] in_val;
	logic [ELEM_BITS-1:0]       in_elem;
	logic                       a_we, b_we;
	logic [ADDR_W-1:0]          waddr, a_raddr, b_raddr;
	logic [ELEM_BITS-1:0]       a_rdata, b_rdata;

	mac_ctl_t                mac_ctl;
	logic signed [ACC_W-1:0] mac_acc;
	logic                    mac_done;
	logic                    start, out_free, out_load;

	logic signed [SAT_W-1:0]   acc_wide;
	logic [SAT_W-VAL_W:0]      acc_hi;
	logic [VAL_W-1:0]          sat_val;

	logic                   out_valid_q, out_last_q;
	logic [IDX_W-1:0]       out_row_q, out_col_q;
	logic [VAL_W-1:0]       out_value_q;

	// input word unpacking
	assign kind    = kind_t'(s_axis_tuser);
	assign in_row  = s_axis_tdata[IDX_W-1:0];
	assign in_col  = s_axis_tdata[2*IDX_W-1:IDX_W];
	assign in_val  = signed'(s_axis_tdata[2*IDX_W+IN_VAL_W-1:2*IDX_W]);
	assign in_elem = ELEM_BITS'(in_val);
	assign s_acc   = s_axis_tvalid && s_axis_tready;
	assign start   = s_acc && (kind == KIND_COMPUTE);

	assign a_we = s_acc && (kind == KIND_LOAD_A) &&
		(CFG_W'(in_row) < a_rows_q) && (CFG_W'(in_col) < inner_size_q);
	assign b_we = s_acc && (kind == KIND_LOAD_B) &&
		(CFG_W'(in_row) < inner_size_q) && (CFG_W'(in_col) < b_cols_q);
	assign waddr   = {in_row[DIM_W-1:0], in_col[DIM_W-1:0]};
	assign a_raddr = {i_q, k_q};
	assign b_raddr = {k_q, j_q};

	// size registers, 0 acts as 1 and anything above MAX_DIM as MAX_DIM
	always_comb begin
		if (cfg_wdata == '0) begin
			cfg_clamped = CFG_W'(1);
		end else if (cfg_wdata > CFG_W'(MAX_DIM)) begin
			cfg_clamped = CFG_W'(MAX_DIM);
		end else begin
			cfg_clamped = cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			a_rows_q     <= CFG_W'(MAX_DIM);
			inner_size_q <= CFG_W'(MAX_DIM);
			b_cols_q     <= CFG_W'(MAX_DIM);
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_A_ROWS:     a_rows_q     <= cfg_clamped;
				REG_INNER_SIZE: inner_size_q <= cfg_clamped;
				REG_B_COLS:     b_cols_q     <= cfg_clamped;
				default: ;
			endcase
		end
	end

	mme_ram #(.WIDTH(ELEM_BITS), .DEPTH(DEPTH)) u_a_store (
		.clk   (clk),
		.we    (a_we),
		.waddr (waddr),
		.wdata (in_elem),
		.raddr (a_raddr),
		.rdata (a_rdata)
	);

	mme_ram #(.WIDTH(ELEM_BITS), .DEPTH(DEPTH)) u_b_store (
		.clk   (clk),
		.we    (b_we),
		.waddr (waddr),
		.wdata (in_elem),
		.raddr (b_raddr),
		.rdata (b_rdata)
	);

	mme_mac #(.ELEM_BITS(ELEM_BITS), .ACC_W(ACC_W)) u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (mac_ctl),
		.a_elem (a_rdata),
		.b_elem (b_rdata),
		.acc    (mac_acc),
		.done   (mac_done)
	);

	assign i_last   = (CFG_W'(i_q) + CFG_W'(1)) == a_rows_q;
	assign j_last   = (CFG_W'(j_q) + CFG_W'(1)) == b_cols_q;
	assign k_last   = (CFG_W'(k_q) + CFG_W'(1)) == inner_size_q;
	assign out_free = !out_valid_q || m_axis_tready;

	// sequencer next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (start) state_d = ST_READ;
			end
			ST_READ: state_d = ST_LOAD;
			ST_LOAD: state_d = ST_MUL;
			ST_MUL: begin
				if (mac_done) state_d = k_last ? ST_EMIT : ST_READ;
			end
			ST_EMIT: begin
				if (out_free) state_d = (i_last && j_last) ? ST_IDLE : ST_READ;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		s_axis_tready = 1'b0;
		mac_ctl       = '0;
		out_load      = 1'b0;
		case (state_q)
			ST_IDLE: begin
				s_axis_tready = 1'b1;
				mac_ctl.clr   = start;
			end
			ST_LOAD: mac_ctl.load = 1'b1;
			ST_MUL:  mac_ctl.step = 1'b1;
			ST_EMIT: begin
				out_load    = out_free;
				mac_ctl.clr = out_free;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			i_q     <= '0;
			j_q     <= '0;
			k_q     <= '0;
		end else begin
			state_q <= state_d;
			if (start) begin
				i_q <= '0;
				j_q <= '0;
				k_q <= '0;
			end else if (state_q == ST_MUL && mac_done && !k_last) begin
				k_q <= k_q + DIM_W'(1);
			end else if (out_load) begin
				k_q <= '0;
				if (j_last) begin
					j_q <= '0;
					i_q <= i_last ? '0 : (i_q + DIM_W'(1));
				end else begin
					j_q <= j_q + DIM_W'(1);
				end
			end
		end
	end

	// clamp the sum to the 36-bit result range
	assign acc_wide = SAT_W'(mac_acc);
	assign acc_hi   = acc_wide[SAT_W-1:VAL_W-1];
	always_comb begin
		if ((&acc_hi) || !(|acc_hi)) begin
			sat_val = acc_wide[VAL_W-1:0];
		end else if (acc_wide[SAT_W-1]) begin
			sat_val = {1'b1, {(VAL_W-1){1'b0}}};
		end else begin
			sat_val = {1'b0, {(VAL_W-1){1'b1}}};
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_row_q   <= IDX_W'(i_q);
			out_col_q   <= IDX_W'(j_q);
			out_value_q <= sat_val;
			out_last_q  <= i_last && j_last;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tlast  = out_last_q;
	assign m_axis_tdata  = {(OUT_TDATA_W - VAL_W - 2 * IDX_W)'(0),
		out_value_q, out_col_q, out_row_q};

	a_counters_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != ST_IDLE |-> (CFG_W'(i_q) < a_rows_q) && (CFG_W'(j_q) < b_cols_q)
			&& (CFG_W'(k_q) < inner_size_q))
		else $error("sequencer index outside configured size");

	a_mul_runs_to_msb: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_MUL && !mac_done) |=> state_q == ST_MUL)
		else $error("multiplier left before its last bit");

	a_last_ends_product: assert property (@(posedge clk) disable iff (!arst_n)
		(out_load && i_last && j_last) |=> (state_q == ST_IDLE) && out_last_q && out_valid_q)
		else $error("final element not marked or sequencer not idle");

	a_no_store_write_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(a_we || b_we) |-> state_q == ST_IDLE && !(a_we && b_we))
		else $error("store written outside idle");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !m_axis_tready) |-> !out_load)
		else $error("pending result overwritten");

endmodule
